>>> rtl/gated_audio_trapezoid_envelope_top_defines.svh
// Assertion macros used by the port-level checker of the gated audio envelope block.
`ifndef GATED_AUDIO_TRAPEZOID_ENVELOPE_TOP_DEFINES_SVH
`define GATED_AUDIO_TRAPEZOID_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GATE_ENV_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GATE_ENV_ASSERT_NEXT(label, clk, ante, cons, rstn, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define GATE_ENV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gate_env_pkg.sv
// Shared constants, codes and types of the gated audio envelope block.
package gate_env_pkg;

    // Field widths.
    localparam int SAMPLE_BITS    = 16;
    localparam int POSITION_BITS  = 20;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((2 * SAMPLE_BITS + GAIN_BITS + 7) / 8) * 8;
    localparam int GAIN_LSB       = 2 * SAMPLE_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = POSITION_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_PERIOD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_ON     = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_FADE   = CFG_INDEX_BITS'(2);

    // Register reset values and their adjusted active copies.
    localparam logic [POSITION_BITS-1:0] RESET_PERIOD = POSITION_BITS'(48000);
    localparam logic [POSITION_BITS-1:0] RESET_ON     = POSITION_BITS'(24000);
    localparam logic [POSITION_BITS-1:0] RESET_FADE   = POSITION_BITS'(480);

    // Gain classes decided by the front end.
    localparam int KIND_BITS = 2;
    localparam logic [KIND_BITS-1:0] KIND_UNITY = KIND_BITS'(0);
    localparam logic [KIND_BITS-1:0] KIND_ZERO  = KIND_BITS'(1);
    localparam logic [KIND_BITS-1:0] KIND_RAMP  = KIND_BITS'(2);

    // Gain arithmetic.
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(GAIN_BITS - 1);
    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic [PROD_BITS-1:0] TRUNC_BIAS = (PROD_BITS'(1) << GAIN_FRAC_BITS) - 1'b1;

    // Queue between front and back.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // One classified frame handed from front to back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [KIND_BITS-1:0]          kind;
        logic [POSITION_BITS-1:0]      ramp;
        logic [POSITION_BITS-1:0]      fade;
    } gate_env_item_t;

endpackage

>>> rtl/gate_env_front.sv
// Front end: configuration staging, period latching, frame counter and gain class.
module gate_env_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [gate_env_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                    cfg_we,
    input  logic [gate_env_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gate_env_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                    push_valid,
    input  logic                                    push_ready,
    output gate_env_pkg::gate_env_item_t            push_item
);
    import gate_env_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_LATCH = 2'd1;
    localparam logic [1:0] F_FADE  = 2'd2;
    localparam logic [1:0] F_CLASS = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [POSITION_BITS-1:0] gate_period_reg, gate_period_next;
    logic [POSITION_BITS-1:0] gate_on_reg, gate_on_next;
    logic [POSITION_BITS-1:0] gate_fade_reg, gate_fade_next;
    logic pending_reg, pending_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] act_period_reg, act_period_next;
    logic [POSITION_BITS-1:0] act_on_reg, act_on_next;
    logic [POSITION_BITS-1:0] act_fade_reg, act_fade_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;

    logic [POSITION_BITS-1:0] period_eff, on_lim, half_gap, fade_m1, fade_lim;
    logic signed [POSITION_BITS+1:0] out_r, in_r, ramp_r;
    logic [KIND_BITS-1:0] kind;
    logic [POSITION_BITS:0] pos_inc;

    // Adjusted settings: a zero period counts as one, on and fade are limited.
    always_comb begin
        period_eff = (gate_period_reg == '0) ? POSITION_BITS'(1) : gate_period_reg;
        on_lim     = (gate_on_reg < period_eff) ? gate_on_reg : period_eff;
        half_gap   = (act_period_reg - act_on_reg) >> 1;
        fade_m1    = (gate_fade_reg < half_gap) ? gate_fade_reg : half_gap;
        fade_lim   = (fade_m1 < act_on_reg) ? fade_m1 : act_on_reg;
    end

    // Gain class of the current position; the ramp value is the larger of the two slopes.
    always_comb begin
        out_r  = $signed({2'b00, act_fade_reg}) + $signed({2'b00, act_on_reg})
               - $signed({2'b00, pos_reg});
        in_r   = $signed({2'b00, act_fade_reg}) + $signed({2'b00, pos_reg})
               - $signed({2'b00, act_period_reg});
        ramp_r = (out_r > in_r) ? out_r : in_r;
        if (pos_reg < act_on_reg) begin
            kind = KIND_UNITY;
        end else if (act_fade_reg == '0 || ramp_r <= 0) begin
            kind = KIND_ZERO;
        end else begin
            kind = KIND_RAMP;
        end
    end

    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_CLASS);

    always_comb begin
        push_item.left  = left_reg;
        push_item.right = right_reg;
        push_item.kind  = kind;
        push_item.ramp  = ramp_r[POSITION_BITS-1:0];
        push_item.fade  = act_fade_reg;
    end

    // Sequencer of one frame through latch, fade limit and classification.
    always_comb begin
        state_next       = state_reg;
        gate_period_next = gate_period_reg;
        gate_on_next     = gate_on_reg;
        gate_fade_next   = gate_fade_reg;
        pending_next     = pending_reg;
        pos_next         = pos_reg;
        act_period_next  = act_period_reg;
        act_on_next      = act_on_reg;
        act_fade_next    = act_fade_reg;
        left_next        = left_reg;
        right_next       = right_reg;

        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    left_next  = s_tdata[SAMPLE_BITS-1:0];
                    right_next = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                    state_next = F_LATCH;
                end
            end
            F_LATCH: begin
                if (pos_reg == '0 && pending_reg) begin
                    act_period_next = period_eff;
                    act_on_next     = on_lim;
                    pending_next    = 1'b0;
                    state_next      = F_FADE;
                end else begin
                    state_next = F_CLASS;
                end
            end
            F_FADE: begin
                act_fade_next = fade_lim;
                state_next    = F_CLASS;
            end
            F_CLASS: begin
                if (push_ready) begin
                    pos_next   = (pos_inc == {1'b0, act_period_reg}) ? '0
                                                                     : pos_inc[POSITION_BITS-1:0];
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase

        // Register writes are staged until the next period boundary.
        if (cfg_we) begin
            unique case (cfg_index)
                REG_GATE_PERIOD: begin
                    gate_period_next = cfg_data;
                    pending_next     = 1'b1;
                end
                REG_GATE_ON: begin
                    gate_on_next = cfg_data;
                    pending_next = 1'b1;
                end
                REG_GATE_FADE: begin
                    gate_fade_next = cfg_data;
                    pending_next   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            gate_period_reg <= RESET_PERIOD;
            gate_on_reg     <= RESET_ON;
            gate_fade_reg   <= RESET_FADE;
            pending_reg     <= 1'b0;
            pos_reg         <= '0;
            act_period_reg  <= RESET_PERIOD;
            act_on_reg      <= RESET_ON;
            act_fade_reg    <= RESET_FADE;
        end else begin
            state_reg       <= state_next;
            gate_period_reg <= gate_period_next;
            gate_on_reg     <= gate_on_next;
            gate_fade_reg   <= gate_fade_next;
            pending_reg     <= pending_next;
            pos_reg         <= pos_next;
            act_period_reg  <= act_period_next;
            act_on_reg      <= act_on_next;
            act_fade_reg    <= act_fade_next;
        end
    end

    // Sample payload needs no reset.
    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

endmodule

>>> rtl/gate_env_queue.sv
// Short FIFO that decouples the front end from the back end.
module gate_env_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push_valid,
    output logic                         push_ready,
    input  gate_env_pkg::gate_env_item_t push_item,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output gate_env_pkg::gate_env_item_t pop_item
);
    import gate_env_pkg::*;

    gate_env_item_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/gate_env_back.sv
// Back end: serial gain divider, sample multiply, truncation and output register.
module gate_env_back (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      pop_valid,
    output logic                                      pop_ready,
    input  gate_env_pkg::gate_env_item_t              pop_item,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic signed [gate_env_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [gate_env_pkg::SAMPLE_BITS-1:0] right_out,
    output logic [gate_env_pkg::GAIN_BITS-1:0]        gain_used
);
    import gate_env_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_MUL  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;
    logic [POSITION_BITS-1:0] fade_reg, fade_next;
    logic [POSITION_BITS:0] rem_reg, rem_next;
    logic [GAIN_BITS-1:0] gain_reg, gain_next;
    logic signed [PROD_BITS-1:0] prod_l_reg, prod_l_next;
    logic signed [PROD_BITS-1:0] prod_r_reg, prod_r_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_BITS-1:0] right_out_reg, right_out_next;
    logic [GAIN_BITS-1:0] gain_out_reg, gain_out_next;

    logic [POSITION_BITS:0] trial;
    logic trial_ge;
    logic signed [PROD_BITS-1:0] adj_l, adj_r, shr_l, shr_r;
    logic out_free;

    assign pop_ready = (state_reg == B_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign gain_used = gain_out_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // One restoring division step: the first step compares the ramp itself.
    always_comb begin
        trial    = (cnt_reg == '0) ? rem_reg : (rem_reg << 1);
        trial_ge = (trial >= {1'b0, fade_reg});
    end

    // Truncation toward zero of the scaled products.
    always_comb begin
        adj_l = prod_l_reg[PROD_BITS-1] ? prod_l_reg + $signed(TRUNC_BIAS) : prod_l_reg;
        adj_r = prod_r_reg[PROD_BITS-1] ? prod_r_reg + $signed(TRUNC_BIAS) : prod_r_reg;
        shr_l = adj_l >>> GAIN_FRAC_BITS;
        shr_r = adj_r >>> GAIN_FRAC_BITS;
    end

    // Back-end sequencer.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        fade_next      = fade_reg;
        rem_next       = rem_reg;
        gain_next      = gain_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        gain_out_next  = gain_out_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    left_next  = pop_item.left;
                    right_next = pop_item.right;
                    fade_next  = pop_item.fade;
                    rem_next   = {1'b0, pop_item.ramp};
                    cnt_next   = '0;
                    if (pop_item.kind == KIND_RAMP) begin
                        gain_next  = '0;
                        state_next = B_DIV;
                    end else begin
                        gain_next  = (pop_item.kind == KIND_UNITY) ? GAIN_UNITY : '0;
                        state_next = B_MUL;
                    end
                end
            end
            B_DIV: begin
                rem_next  = trial_ge ? trial - {1'b0, fade_reg} : trial;
                gain_next = {gain_reg[GAIN_BITS-2:0], trial_ge};
                if (cnt_reg == DIV_LAST) begin
                    state_next = B_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_MUL: begin
                prod_l_next = left_reg * $signed({1'b0, gain_reg});
                prod_r_next = right_reg * $signed({1'b0, gain_reg});
                state_next  = B_OUT;
            end
            B_OUT: begin
                if (out_free) begin
                    left_out_next  = shr_l[SAMPLE_BITS-1:0];
                    right_out_next = shr_r[SAMPLE_BITS-1:0];
                    gain_out_next  = gain_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        fade_reg      <= fade_next;
        rem_reg       <= rem_next;
        gain_reg      <= gain_next;
        prod_l_reg    <= prod_l_next;
        prod_r_reg    <= prod_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        gain_out_reg  <= gain_out_next;
    end

endmodule

>>> rtl/gated_audio_trapezoid_envelope_top.sv
// Top level of the gated stereo audio block with a trapezoid gain envelope.
// A beat passes the front end (latch, a fade-limit step on a frame that latches pending settings
// at a period boundary, classify), the queue, and the back end (the 16-step serial gain divider
// on a ramp only, multiply, output register); the front end takes no new beat and the back end
// no new frame until it is through with the last one.
// Reset: synchronous, active low; registers return to 48000/24000/480, position to zero.
module gated_audio_trapezoid_envelope_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: left_in[15:0], right_in[31:16].
    input  logic [gate_env_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // Fields from bit 0: left_out[15:0], right_out[31:16], gain_used[47:32].
    output logic [gate_env_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  logic                                    cfg_we,
    input  logic [gate_env_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gate_env_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import gate_env_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    gate_env_item_t push_item, pop_item;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;
    logic [GAIN_BITS-1:0] gain_used;

    // Front end: settings and classification.
    gate_env_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue.
    gate_env_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: gain and scaling.
    gate_env_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .left_out  (left_out),
        .right_out (right_out),
        .gain_used (gain_used)
    );

    // Output beat packing, zero padded to whole bytes.
    assign m_tdata = OUT_DATA_BITS'({gain_used, right_out, left_out});

endmodule

>>> rtl/gate_env_checker.sv
// Port-level checker of the gated audio envelope block and its bind.
`include "gated_audio_trapezoid_envelope_top_defines.svh"

module gate_env_props (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [gate_env_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import gate_env_pkg::*;

    logic [GAIN_BITS-1:0] gain_field;
    logic [2*SAMPLE_BITS-1:0] sample_fields;

    assign gain_field    = m_tdata[GAIN_LSB +: GAIN_BITS];
    assign sample_fields = m_tdata[2*SAMPLE_BITS-1:0];

    // A stalled result beat keeps its payload.
    `GATE_ENV_ASSERT_NEXT(a_out_hold, aclk, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), aresetn, "result beat changed while stalled")

    // The gain never exceeds unity.
    `GATE_ENV_ASSERT_IMPLY(a_gain_range, aclk, aresetn, m_tvalid, gain_field <= GAIN_UNITY, "gain above unity")

    // A zero gain silences both channels.
    `GATE_ENV_ASSERT_IMPLY(a_zero_mute, aclk, aresetn, m_tvalid && gain_field == '0, sample_fields == '0, "nonzero sample at zero gain")

    // No result is offered right after a reset cycle.
    `GATE_ENV_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind gated_audio_trapezoid_envelope_top gate_env_props u_gate_env_props (.*);

>>> tb/gate_env_checker.sv
// Checker that predicts every gated stereo frame and compares it with the result stream.
module gate_env_checker
    import gate_env_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_DATA_BITS-1:0]  m_tdata,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatch_count,
    output int                        frames_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // Keep the console readable when the block is badly broken.
    localparam int PRINT_CAP = 50;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [GAIN_BITS-1:0]          gain;
    } gated_frame_t;

    gated_frame_t expected_frames[$];

    // Staged register copies, written by the configuration port.
    logic [POSITION_BITS-1:0] staged_period;
    logic [POSITION_BITS-1:0] staged_on;
    logic [POSITION_BITS-1:0] staged_fade;
    logic                     change_pending;

    // Envelope settings in force and the position within the period.
    logic [POSITION_BITS-1:0] active_period;
    logic [POSITION_BITS-1:0] active_on;
    logic [POSITION_BITS-1:0] active_fade;
    logic [POSITION_BITS-1:0] frame_pos;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] ERROR %s: got %0d, expected %0d", $realtime, field, got, want);
        end
        mismatch_count++;
    endtask

    // Take over the staged registers; the fade is limited by the already-limited on span.
    function automatic void latch_gate_settings();
        logic [POSITION_BITS-1:0] period;
        logic [POSITION_BITS-1:0] on_span;
        logic [POSITION_BITS-1:0] fade_cap;
        period   = (staged_period == '0) ? POSITION_BITS'(1) : staged_period;
        on_span  = (staged_on < period) ? staged_on : period;
        fade_cap = (period - on_span) >> 1;
        if (on_span < fade_cap) begin
            fade_cap = on_span;
        end
        active_period = period;
        active_on     = on_span;
        active_fade   = (staged_fade < fade_cap) ? staged_fade : fade_cap;
    endfunction

    // Trapezoid gain at position k: unity, ramp down, zero, ramp up.
    function automatic logic [GAIN_BITS-1:0] envelope_gain(input logic [POSITION_BITS-1:0] k);
        longint pos_l;
        longint on_l;
        longint period_l;
        longint fade_l;
        longint unity_l;
        longint fall;
        longint rise;
        longint ramp;
        pos_l    = k;
        on_l     = active_on;
        period_l = active_period;
        fade_l   = active_fade;
        unity_l  = GAIN_UNITY;
        if (k < active_on) begin
            return GAIN_UNITY;
        end
        if (fade_l == 0) begin
            return '0;
        end
        fall = fade_l - (pos_l - on_l);
        rise = fade_l - (period_l - pos_l);
        ramp = (fall > rise) ? fall : rise;
        if (ramp <= 0) begin
            return '0;
        end
        return GAIN_BITS'((ramp * unity_l) / fade_l);
    endfunction

    // Advance the envelope by one frame and scale both samples.
    function automatic gated_frame_t predict_frame(input logic [IN_DATA_BITS-1:0] beat);
        gated_frame_t frame;
        longint       left_l;
        longint       right_l;
        longint       gain_l;
        longint       unity_l;
        logic [GAIN_BITS-1:0] gain;
        left_l  = $signed(beat[SAMPLE_BITS-1:0]);
        right_l = $signed(beat[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        unity_l = GAIN_UNITY;
        if (frame_pos >= active_period) begin
            frame_pos = '0;
        end
        // Pending register writes only take effect at a period boundary.
        if (frame_pos == '0 && change_pending) begin
            latch_gate_settings();
            change_pending = 1'b0;
        end
        gain   = envelope_gain(frame_pos);
        gain_l = gain;
        frame.left  = SAMPLE_BITS'((left_l * gain_l) / unity_l);
        frame.right = SAMPLE_BITS'((right_l * gain_l) / unity_l);
        frame.gain  = gain;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos >= active_period) begin
            frame_pos = '0;
        end
        return frame;
    endfunction

    // Result beats are checked before the input beat of the same edge is queued.
    always @(posedge aclk) begin
        gated_frame_t want;
        gated_frame_t got;
        if (!aresetn) begin
            staged_period  = RESET_PERIOD;
            staged_on      = RESET_ON;
            staged_fade    = RESET_FADE;
            change_pending = 1'b0;
            latch_gate_settings();
            frame_pos = '0;
            expected_frames.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.left  = m_tdata[SAMPLE_BITS-1:0];
                got.right = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                got.gain  = m_tdata[GAIN_LSB +: GAIN_BITS];
                if (expected_frames.size() == 0) begin
                    report_mismatch("result beat with no frame outstanding", got.gain, 0);
                end else begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left) begin
                        report_mismatch("left_out", got.left, want.left);
                    end
                    if (got.right !== want.right) begin
                        report_mismatch("right_out", got.right, want.right);
                    end
                    if (got.gain !== want.gain) begin
                        report_mismatch("gain_used", got.gain, want.gain);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_GATE_PERIOD: begin
                        staged_period  = cfg_data;
                        change_pending = 1'b1;
                    end
                    REG_GATE_ON: begin
                        staged_on      = cfg_data;
                        change_pending = 1'b1;
                    end
                    REG_GATE_FADE: begin
                        staged_fade    = cfg_data;
                        change_pending = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_frames.push_back(predict_frame(s_tdata));
            end
        end
        frames_in_flight = expected_frames.size();
    end

endmodule

>>> tb/gated_audio_trapezoid_envelope_top_tb.sv
// Stimulus and verdict for the gated stereo audio envelope block.
module gated_audio_trapezoid_envelope_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gate_env_pkg::*;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 5;
    localparam int CYCLE_LIMIT       = 500_000;
    localparam int DRAIN_CYCLES      = 40;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DIRECTED_FRAMES   = 20;
    localparam int NUM_PHASES        = 9;
    localparam int FRAMES_PER_PHASE  = 75;
    localparam int RANDOM_PHASE      = 7;
    localparam int STALL_PHASE       = 1;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(3);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    // Fields from bit 0: left_in[15:0], right_in[31:16].
    logic [IN_DATA_BITS-1:0]   s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    // Fields from bit 0: left_out[15:0], right_out[31:16], gain_used[47:32].
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int          mismatch_count;
    int          frames_in_flight;
    int unsigned cycle_count;
    int          tx_idle_pct = 22;
    int          rx_idle_pct = 65;
    logic        long_stall_armed = 1'b0;
    logic        long_stall_done;

    // Directed frames walk the unity, ramp down, zero and ramp up spans twice.
    shortint dir_left[DIRECTED_FRAMES] = '{32767, -32768, 0, -1, 1, 32767, -32768, 12345,
                                           -32768, 32767, -1, -32767, 21845, -32768, 32767,
                                           100, -3, 32767, -32768, -1};
    shortint dir_right[DIRECTED_FRAMES] = '{-32768, 32767, 0, 1, -1, 32767, -32768, -12345,
                                            32767, -32768, -1, 16384, -21846, 1, 0,
                                            -100, 3, -32768, 32767, 1};

    // Envelope settings per random phase: small periods so every setting gets latched,
    // plus the register extremes; the longest period comes last since it never wraps.
    int unsigned phase_period[NUM_PHASES] = '{16, 0, 1, 25, 12, 40, 7, 0, 1048575};
    int unsigned phase_on[NUM_PHASES]     = '{6, 0, 5, 3, 1048575, 20, 2, 0, 5};
    int unsigned phase_fade[NUM_PHASES]   = '{4, 0, 9, 1048575, 7, 10, 2, 0, 1048575};

    gated_audio_trapezoid_envelope_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gate_env_checker env_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .frames_in_flight (frames_in_flight)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random backpressure, and once a long hold-off to fill the block.
    initial begin
        m_tready = 1'b0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_stall_armed && !long_stall_done) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES - 1) @(negedge aclk);
                long_stall_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one frame after an optional random gap and hold it until the beat is taken.
    task automatic send_frame(input logic [SAMPLE_BITS-1:0] left,
                              input logic [SAMPLE_BITS-1:0] right);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every frame has come back.
    task automatic finish_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_in_flight != 0) @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    initial begin
        int unsigned period;
        int unsigned on_span;
        int unsigned fade;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Period 10, on 4, fade 3 gives full, ramp, zero and rising spans in one period.
        write_reg(REG_GATE_PERIOD, CFG_DATA_BITS'(10));
        write_reg(REG_GATE_ON, CFG_DATA_BITS'(4));
        write_reg(REG_GATE_FADE, CFG_DATA_BITS'(3));
        write_reg(REG_UNUSED, '1);
        for (int i = 0; i < DIRECTED_FRAMES; i++) begin
            send_frame(dir_left[i], dir_right[i]);
        end
        finish_burst();

        // Random phases, each under its own envelope setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 22;
                rx_idle_pct = 65;
            end else if (ph < 6) begin
                tx_idle_pct = 65;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            period  = phase_period[ph];
            on_span = phase_on[ph];
            fade    = phase_fade[ph];
            if (ph == RANDOM_PHASE) begin
                period  = $urandom_range(64, 2);
                on_span = $urandom_range(70, 0);
                fade    = $urandom_range(40, 0);
            end
            if (ph % 2 == 0) begin
                write_reg(REG_GATE_PERIOD, CFG_DATA_BITS'(period));
                write_reg(REG_GATE_ON, CFG_DATA_BITS'(on_span));
                write_reg(REG_GATE_FADE, CFG_DATA_BITS'(fade));
            end else begin
                write_reg(REG_GATE_FADE, CFG_DATA_BITS'(fade));
                write_reg(REG_GATE_ON, CFG_DATA_BITS'(on_span));
                write_reg(REG_GATE_PERIOD, CFG_DATA_BITS'(period));
            end
            if (ph == STALL_PHASE) begin
                long_stall_armed = 1'b1;
            end
            for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
                send_frame(random_sample(), random_sample());
            end
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/gate_env_pkg.sv
rtl/gate_env_front.sv
rtl/gate_env_queue.sv
rtl/gate_env_back.sv
rtl/gated_audio_trapezoid_envelope_top.sv
rtl/gate_env_checker.sv
tb/gate_env_checker.sv
tb/gated_audio_trapezoid_envelope_top_tb.sv
